/* design/cfr_pkg.sv */
package cfr_pkg;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_DATA = 2'd1,
      PH_CSUM = 2'd2
   } cfr_phase_type;

   localparam logic [7:0] HELLO_BYTE     = 8'hAA;
   localparam logic [7:0] HANDSHAKE_BYTE = 8'hBB;
   localparam logic [7:0] ACK_BYTE       = 8'h00;
   localparam logic [7:0] NAK_BYTE       = 8'hFF;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [3:0] data_index;
      logic       frame_done;
      logic       frame_ok;
   } cfr_result_type;

endpackage

/* design/cfr_step.sv */
module cfr_step import cfr_pkg::*; #(
   parameter int FRAME_LEN  = 10,
   parameter int CountWidth = 4
) (
   input  cfr_phase_type        phase,
   input  logic [CountWidth-1:0] byte_count,
   input  logic [7:0]           running_sum,
   input  logic [7:0]           rx_byte,
   output cfr_phase_type        phase_next,
   output logic [CountWidth-1:0] byte_count_next,
   output logic [7:0]           running_sum_next,
   output cfr_result_type       result
);

   localparam logic [CountWidth-1:0] FrameLen = CountWidth'(FRAME_LEN);

   logic [CountWidth-1:0] count_inc;
   logic [CountWidth+3:0] count_ext;

   assign count_inc = byte_count + CountWidth'(1);
   assign count_ext = {4'b0000, byte_count};

   always_comb begin
      phase_next       = PH_WAIT;
      byte_count_next  = '0;
      running_sum_next = '0;
      result           = '0;
      case (phase)
         PH_DATA: begin
            result.data_valid = 1'b1;
            result.data_byte  = rx_byte;
            // index wraps on frames longer than 16 bytes
            result.data_index = count_ext[3:0];
            running_sum_next  = running_sum + rx_byte;
            byte_count_next   = count_inc;
            phase_next        = (count_inc >= FrameLen) ? PH_CSUM : PH_DATA;
         end
         PH_CSUM: begin
            result.frame_done = 1'b1;
            result.tx_valid   = 1'b1;
            if (rx_byte == running_sum) begin
               result.frame_ok = 1'b1;
               result.tx_byte  = ACK_BYTE;
               phase_next      = PH_WAIT;
            end else begin
               // nak: expect the payload again without a new hello
               result.tx_byte = NAK_BYTE;
               phase_next     = PH_DATA;
            end
         end
         default: begin
            if (rx_byte == HELLO_BYTE) begin
               result.tx_valid = 1'b1;
               result.tx_byte  = HANDSHAKE_BYTE;
               phase_next      = PH_DATA;
            end
         end
      endcase
   end

endmodule

/* design/checksum_frame_receiver_core.sv */
// channel   direction  handshake           payload
// req       in         req_valid/req_stall  req_rx_byte
// rsp       out        rsp_valid/rsp_stall  rsp_tx_*, rsp_data_*, rsp_frame_*
//
// one received byte per cycle while req_stall is low; each byte gives one result, passing
// through the input register, then the phase/sum update into the result register
// synchronous active-high reset returns to waiting for hello with count and sum cleared
// rsp_stall holds the result register; the input register still takes a byte while the
// result register waits, and req_stall rises only once both are full
module checksum_frame_receiver_core import cfr_pkg::*; #(
   parameter int FRAME_LEN = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_data_valid,
   output logic [7:0] rsp_data_byte,
   output logic [3:0] rsp_data_index,
   output logic       rsp_frame_done,
   output logic       rsp_frame_ok
);

   localparam int CountWidth = $clog2(FRAME_LEN + 1);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;
   cfr_phase_type         phase_ff, phase_in, phase_step;
   logic [CountWidth-1:0] count_ff, count_in, count_step;
   logic [7:0]            sum_ff, sum_in, sum_step;
   logic                  out_valid_ff, out_valid_in;
   cfr_result_type        out_ff, out_in, result_step;
   logic                  out_load;
   logic                  stage_move;
   logic                  req_take;

   cfr_step #(
      .FRAME_LEN  (FRAME_LEN),
      .CountWidth (CountWidth)
   ) u_step (
      .phase            (phase_ff),
      .byte_count       (count_ff),
      .running_sum      (sum_ff),
      .rx_byte          (in_byte_ff),
      .phase_next       (phase_step),
      .byte_count_next  (count_step),
      .running_sum_next (sum_step),
      .result           (result_step)
   );

   assign out_load   = !out_valid_ff || !rsp_stall;
   assign stage_move = in_valid_ff && out_load;
   assign req_stall  = in_valid_ff && !out_load;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      in_byte_in   = req_take ? req_rx_byte : in_byte_ff;
      phase_in     = stage_move ? phase_step : phase_ff;
      count_in     = stage_move ? count_step : count_ff;
      sum_in       = stage_move ? sum_step : sum_ff;
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
      out_in       = stage_move ? result_step : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_WAIT;
         count_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_tx_valid   = out_ff.tx_valid;
   assign rsp_tx_byte    = out_ff.tx_byte;
   assign rsp_data_valid = out_ff.data_valid;
   assign rsp_data_byte  = out_ff.data_byte;
   assign rsp_data_index = out_ff.data_index;
   assign rsp_frame_done = out_ff.frame_done;
   assign rsp_frame_ok   = out_ff.frame_ok;

endmodule

/* design/cfr_checker.sv */
module cfr_checker import cfr_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_data_valid,
   input logic [7:0] rsp_data_byte,
   input logic [3:0] rsp_data_index,
   input logic       rsp_frame_done,
   input logic       rsp_frame_ok
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte)
         && $stable(rsp_data_byte) && $stable(rsp_frame_done))
      else $error("result changed under stall");

   // a byte is either payload or answered, never both
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tx_valid && rsp_data_valid))
      else $error("reply and payload in one result");

   // checksum byte always gets ack or nak matching frame_ok
   a_ack_nak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |->
         rsp_tx_valid && ((rsp_frame_ok && rsp_tx_byte == ACK_BYTE)
         || (!rsp_frame_ok && rsp_tx_byte == NAK_BYTE)))
      else $error("checksum reply mismatch");

   // unused fields read as zero
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_valid |->
         rsp_data_byte == 8'h00 && rsp_data_index == 4'h0)
      else $error("payload fields nonzero without payload");

   a_reply_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid && !rsp_frame_done |-> rsp_tx_byte == HANDSHAKE_BYTE)
      else $error("reply outside checksum is not the handshake byte");

endmodule

bind checksum_frame_receiver_core cfr_checker u_cfr_checker (.*);

/* sim/checksum_frame_receiver_checker.sv */
module checksum_frame_receiver_checker import cfr_pkg::*; #(
   parameter int FRAME_LEN = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_tx_valid,
   input  logic [7:0] rsp_tx_byte,
   input  logic       rsp_data_valid,
   input  logic [7:0] rsp_data_byte,
   input  logic [3:0] rsp_data_index,
   input  logic       rsp_frame_done,
   input  logic       rsp_frame_ok,
   output int         fail_count,
   output int         pending_count,
   output int         ack_count,
   output int         nak_count
);

   cfr_phase_type  link_phase;
   int             payload_count;
   logic [7:0]     payload_sum;
   cfr_result_type expected_replies[$];
   int             mismatches;
   int             acks;
   int             naks;

   // advances the receiver state by one byte and returns the reply it causes
   function automatic cfr_result_type next_reply(input logic [7:0] rx);
      cfr_result_type r;
      r = '0;
      case (link_phase)
         PH_DATA: begin
            r.data_valid = 1'b1;
            r.data_byte  = rx;
            r.data_index = payload_count[3:0];
            payload_sum  = payload_sum + rx;
            payload_count++;
            if (payload_count >= FRAME_LEN) link_phase = PH_CSUM;
         end
         PH_CSUM: begin
            r.frame_done = 1'b1;
            r.tx_valid   = 1'b1;
            if (rx == payload_sum) begin
               r.frame_ok = 1'b1;
               r.tx_byte  = ACK_BYTE;
               link_phase = PH_WAIT;
            end else begin
               r.tx_byte  = NAK_BYTE;
               link_phase = PH_DATA;
            end
            payload_count = 0;
            payload_sum   = '0;
         end
         default: begin
            // anything but hello is dropped while waiting
            if (rx == HELLO_BYTE) begin
               r.tx_valid = 1'b1;
               r.tx_byte  = HANDSHAKE_BYTE;
               link_phase = PH_DATA;
            end else begin
               link_phase = PH_WAIT;
            end
            payload_count = 0;
            payload_sum   = '0;
         end
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      cfr_result_type want;
      cfr_result_type got;
      if (reset) begin
         link_phase    = PH_WAIT;
         payload_count = 0;
         payload_sum   = '0;
         expected_replies.delete();
         mismatches    = 0;
         acks          = 0;
         naks          = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_tx_valid, rsp_tx_byte, rsp_data_valid, rsp_data_byte,
                   rsp_data_index, rsp_frame_done, rsp_frame_ok};
            if (expected_replies.size() == 0) begin
               $error("result transfer with no byte outstanding");
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
               compare_field("tx_byte", want.tx_byte, got.tx_byte);
               compare_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
               compare_field("data_byte", want.data_byte, got.data_byte);
               compare_field("data_index", 8'(want.data_index), 8'(got.data_index));
               compare_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
               compare_field("frame_ok", 8'(want.frame_ok), 8'(got.frame_ok));
            end
         end
         if (req_valid && !req_stall) begin
            want = next_reply(req_rx_byte);
            if (want.frame_done && want.frame_ok) acks++;
            if (want.frame_done && !want.frame_ok) naks++;
            expected_replies.push_back(want);
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_replies.size();
      ack_count     <= acks;
      nak_count     <= naks;
   end

endmodule

/* sim/tb_checksum_frame_receiver_core.sv */
module tb_checksum_frame_receiver_core;
   import cfr_pkg::*;

   localparam int FRAME_LEN    = 10;
   localparam int TARGET_BYTES = 750;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_data_valid;
   logic [7:0] rsp_data_byte;
   logic [3:0] rsp_data_index;
   logic       rsp_frame_done;
   logic       rsp_frame_ok;

   int fail_count;
   int pending_count;
   int ack_count;
   int nak_count;
   int bytes_sent;
   int frame_bytes;
   bit idle_on;
   bit hold_off_req;

   checksum_frame_receiver_core #(.FRAME_LEN(FRAME_LEN)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_tx_valid(rsp_tx_valid), .rsp_tx_byte(rsp_tx_byte),
      .rsp_data_valid(rsp_data_valid), .rsp_data_byte(rsp_data_byte),
      .rsp_data_index(rsp_data_index), .rsp_frame_done(rsp_frame_done),
      .rsp_frame_ok(rsp_frame_ok)
   );

   checksum_frame_receiver_checker #(.FRAME_LEN(FRAME_LEN)) link_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_tx_valid(rsp_tx_valid), .rsp_tx_byte(rsp_tx_byte),
      .rsp_data_valid(rsp_data_valid), .rsp_data_byte(rsp_data_byte),
      .rsp_data_index(rsp_data_index), .rsp_frame_done(rsp_frame_done),
      .rsp_frame_ok(rsp_frame_ok),
      .fail_count(fail_count), .pending_count(pending_count),
      .ack_count(ack_count), .nak_count(nak_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one byte transfer, with an optional idle burst in front of it
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   function automatic logic [7:0] random_payload_byte();
      case ($urandom_range(0, 7))
         0:       return HELLO_BYTE;
         1:       return 8'h00;
         2:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // payload plus checksum; a bad checksum draws a resend of a fresh payload
   task automatic send_payload_until_ack();
      logic [7:0] sum;
      logic [7:0] b;
      bit         good;
      do begin
         sum = '0;
         for (int i = 0; i < FRAME_LEN; i++) begin
            b = random_payload_byte();
            sum += b;
            send_byte(b);
         end
         good = ($urandom_range(0, 3) != 0);
         send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
         frame_bytes += FRAME_LEN + 1;
      end while (!good);
   endtask

   // receiver side: random stall bursts, plus one long hold-off on request
   initial begin
      int burst;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req <= 1'b0;
            rsp_stall    <= 1'b1;
            repeat (50) @(posedge clock);
            rsp_stall    <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 7);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [7:0] directed_payload[FRAME_LEN] = '{8'hFF, HELLO_BYTE, 8'h00, 8'h01, 8'h80,
                                                   8'h7F, 8'h55, 8'hFF, HELLO_BYTE, 8'h12};
      logic [7:0] sum;
      logic [7:0] noise;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = '0;
      idle_on      = 1'b1;
      hold_off_req = 1'b0;
      bytes_sent   = 0;
      frame_bytes  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: bytes ignored while waiting, hello, a rejected frame with
      // hello bytes and extremes in the payload, then its accepted resend
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HELLO_BYTE);
      sum = '0;
      foreach (directed_payload[i]) begin
         sum += directed_payload[i];
         send_byte(directed_payload[i]);
      end
      send_byte(~sum);
      foreach (directed_payload[i]) send_byte(directed_payload[i]);
      send_byte(sum);

      hold_off_req <= 1'b1;
      while (frame_bytes < TARGET_BYTES) begin
         if (frame_bytes > TARGET_BYTES - 150) idle_on = 1'b0;
         if ($urandom_range(0, 7) == 0) begin
            noise = 8'($urandom_range(0, 255));
            if (noise == HELLO_BYTE) noise = noise ^ 8'h01;
            send_byte(noise);
         end
         send_byte(HELLO_BYTE);
         frame_bytes++;
         send_payload_until_ack();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes, including hello bytes, line noise and resent payloads",
               bytes_sent);
      $display("Frames acknowledged: %0d, rejected with a nak: %0d", ack_count, nak_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
